// File: rtl/core/pht_pkg.sv
// ---------------------------------------------------------------------------
// Print head position tracker package
// Shared widths, register indexes and the divider request/response types.
// ---------------------------------------------------------------------------
package pht_pkg;

    localparam int COL_W       = 8;
    localparam int LINE_W      = 15;
    localparam int PAGE_W      = 16;
    localparam int OFF_W       = 13;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // The divider handles any line value, so its dividend is as wide as a line.
    localparam int DIV_N_W     = LINE_W;
    localparam int DIV_D_W     = CFG_W;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_PER_LINE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_PAGE = 1'b1;

    localparam logic [CFG_W-1:0] CHARS_PER_LINE_RST = 8'd80;
    localparam logic [CFG_W-1:0] LINES_PER_PAGE_RST = 8'd66;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/core/pht_div.sv
// ---------------------------------------------------------------------------
// Print head position tracker divider
// Restoring divider, one quotient bit per cycle, shared by the column and
// page wrap steps.
// ---------------------------------------------------------------------------
module pht_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pht_pkg::div_req_t req,
    output pht_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [pht_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pht_pkg::DIV_N_W-1:0]   quo_reg;
    logic [pht_pkg::DIV_D_W-1:0]   rem_reg;
    logic [pht_pkg::DIV_D_W-1:0]   dvsr_reg;

    logic [pht_pkg::DIV_D_W:0]     trial;
    logic [pht_pkg::DIV_D_W:0]     trial_sub;
    logic                          trial_ge;

    // The partial remainder stays below the divisor, so it fits in DIV_D_W bits.
    always_comb begin
        trial     = {rem_reg, quo_reg[pht_pkg::DIV_N_W-1]};
        trial_ge  = trial >= {1'b0, dvsr_reg};
        trial_sub = trial - {1'b0, dvsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == pht_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg  <= pht_pkg::DIV_CNT_W'(pht_pkg::DIV_STEPS);
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - pht_pkg::DIV_CNT_W'(1);
            rem_reg <= trial_ge ? trial_sub[pht_pkg::DIV_D_W-1:0]
                                : trial[pht_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[pht_pkg::DIV_N_W-2:0], trial_ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // A finished division always leaves a remainder below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dvsr_reg)
        else $error("divider remainder not below divisor");

    // A new request never arrives before the last step of a running division.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg != pht_pkg::DIV_CNT_W'(1) |-> !req.start)
        else $error("divider restarted while busy");

    // The done pulse follows the last step of a running division.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// File: rtl/core/print_head_position_tracker_top.sv
// ---------------------------------------------------------------------------
// Print head position tracker
// Keeps the head column, line and page and moves them by one signed offset
// per input item, producing one result item per move.
// ---------------------------------------------------------------------------
// Usage: an input item carries a mode (0 moves columns, 1 moves lines) and a
// signed offset. It is taken on s_valid && s_ready. Each item yields exactly
// one result item on the m_ channel with the new column, line and page and
// two flags telling whether a line or a page boundary was crossed.
// The two length registers are written through cfg_wen, cfg_index and
// cfg_wdata; the user must write them only while no item is in flight, as
// the block does not enforce it. A length of zero acts as one.
// A vertical move passes the column step and the finish step. A horizontal
// move passes the column step, runs the shared restoring divider once
// (15 steps) if the column wraps, passes the line step, runs the divider
// again if the line then wraps into later pages, and ends in the finish
// step. The single divider produces one quotient bit per cycle. s_ready is
// high only while the sequencer is idle, so the next item is taken in the
// cycle after the previous result is loaded at the earliest.
// The result sits in an output register, so the next item is accepted while
// the previous result waits; a result whose register is still occupied by a
// stalled receiver holds the sequencer until m_ready frees it.
// Reset (aresetn low, synchronous) clears the head position to column 0,
// line 0, page 0, restores the lengths to 80 columns and 66 lines and drops
// any pending result.
// ---------------------------------------------------------------------------
module print_head_position_tracker_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic signed [pht_pkg::OFF_W-1:0] s_offset,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pht_pkg::COL_W-1:0]     m_column,
    output logic [pht_pkg::LINE_W-1:0]    m_line,
    output logic [pht_pkg::PAGE_W-1:0]    m_page,
    output logic                          m_line_moved,
    output logic                          m_page_moved,

    input  logic                          cfg_wen,
    input  logic [pht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pht_pkg::CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_CDIV,
        ST_LINE,
        ST_PDIV,
        ST_FIN
    } state_t;

    state_t                       state_reg;

    // Configuration.
    logic [pht_pkg::CFG_W-1:0]    cpl_reg;
    logic [pht_pkg::CFG_W-1:0]    lpp_reg;
    logic [pht_pkg::CFG_W-1:0]    cpl_eff;
    logic [pht_pkg::CFG_W-1:0]    lpp_eff;

    // Head position.
    logic [pht_pkg::COL_W-1:0]    head_column_reg;
    logic [pht_pkg::LINE_W-1:0]   head_line_reg;
    logic [pht_pkg::PAGE_W-1:0]   page_number_reg;

    // Item being worked on.
    logic                         mode_reg;
    logic [pht_pkg::OFF_W-1:0]    off_reg;
    logic                         fwd_reg;
    logic                         lmoved_reg;
    logic                         pmoved_reg;

    // Output register.
    logic                         m_valid_reg;
    logic [pht_pkg::COL_W-1:0]    m_column_reg;
    logic [pht_pkg::LINE_W-1:0]   m_line_reg;
    logic [pht_pkg::PAGE_W-1:0]   m_page_reg;
    logic                         m_line_moved_reg;
    logic                         m_page_moved_reg;

    pht_pkg::div_req_t            div_req;
    pht_pkg::div_rsp_t            div_rsp;

    logic signed [13:0]           col_sum;
    logic signed [13:0]           col_neg;
    logic                         col_fwd;
    logic                         col_back;
    logic signed [16:0]           vsum;
    logic [pht_pkg::LINE_W-1:0]   vline;
    logic [15:0]                  back_k;
    logic signed [16:0]           hsum;
    logic [pht_pkg::COL_W-1:0]    col_wrapped;
    logic                         line_wrap;
    logic                         out_free;

    function automatic logic [pht_pkg::LINE_W-1:0] sat_line(input logic signed [16:0] v);
        logic [pht_pkg::LINE_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, pht_pkg::LINE_MAX})) begin
            r = pht_pkg::LINE_MAX;
        end else begin
            r = v[pht_pkg::LINE_W-1:0];
        end
        return r;
    endfunction

    assign cpl_eff = (cpl_reg == '0) ? pht_pkg::CFG_W'(1) : cpl_reg;
    assign lpp_eff = (lpp_reg == '0) ? pht_pkg::CFG_W'(1) : lpp_reg;

    always_comb begin
        // Column arithmetic: the head column plus the offset, before wrapping.
        col_sum  = $signed({6'b0, head_column_reg}) + $signed({off_reg[12], off_reg});
        col_neg  = -col_sum;
        col_fwd  = col_sum >= $signed({6'b0, cpl_eff});
        col_back = col_sum[13];

        // Vertical move: clamp the line, the column stays.
        vsum  = $signed({2'b00, head_line_reg}) + $signed({{4{off_reg[12]}}, off_reg});
        vline = sat_line(vsum);

        // After a column division: a backward wrap borrows one more line
        // whenever the remainder is not zero.
        back_k = (div_rsp.remainder == '0) ? {1'b0, div_rsp.quotient}
                                           : {1'b0, div_rsp.quotient} + 16'd1;
        if (fwd_reg) begin
            hsum        = $signed({2'b00, head_line_reg}) + $signed({2'b00, div_rsp.quotient});
            col_wrapped = div_rsp.remainder;
        end else begin
            hsum        = $signed({2'b00, head_line_reg}) - $signed({1'b0, back_k});
            col_wrapped = (div_rsp.remainder == '0) ? '0 : cpl_eff - div_rsp.remainder;
        end

        line_wrap = head_line_reg >= {7'b0, lpp_eff};
        out_free  = !m_valid_reg || m_ready;

        // Divider requests come from the column step and the line step only.
        div_req.start    = 1'b0;
        div_req.dividend = head_line_reg;
        div_req.divisor  = lpp_eff;
        if (state_reg == ST_COL) begin
            div_req.start    = !mode_reg && (col_fwd || col_back);
            div_req.dividend = col_back ? {1'b0, col_neg} : {1'b0, col_sum};
            div_req.divisor  = cpl_eff;
        end else if (state_reg == ST_LINE) begin
            div_req.start = line_wrap;
        end
    end

    pht_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpl_reg <= pht_pkg::CHARS_PER_LINE_RST;
            lpp_reg <= pht_pkg::LINES_PER_PAGE_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                pht_pkg::CFG_CHARS_PER_LINE: cpl_reg <= cfg_wdata;
                pht_pkg::CFG_LINES_PER_PAGE: lpp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer, head position and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            head_column_reg <= '0;
            head_line_reg   <= '0;
            page_number_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // A new result refills the output register; otherwise a taken
            // result empties it.
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        off_reg    <= s_offset;
                        lmoved_reg <= 1'b0;
                        pmoved_reg <= 1'b0;
                        state_reg  <= ST_COL;
                    end
                end
                ST_COL: begin
                    if (mode_reg) begin
                        lmoved_reg    <= off_reg != '0;
                        head_line_reg <= vline;
                        if (vline > {7'b0, lpp_eff}) begin
                            pmoved_reg      <= 1'b1;
                            page_number_reg <= page_number_reg + pht_pkg::PAGE_W'(1);
                        end
                        state_reg <= ST_FIN;
                    end else if (col_fwd || col_back) begin
                        fwd_reg   <= col_fwd;
                        state_reg <= ST_CDIV;
                    end else begin
                        head_column_reg <= col_sum[pht_pkg::COL_W-1:0];
                        state_reg       <= ST_LINE;
                    end
                end
                ST_CDIV: begin
                    if (div_rsp.done) begin
                        head_column_reg <= col_wrapped;
                        head_line_reg   <= sat_line(hsum);
                        lmoved_reg      <= fwd_reg;
                        state_reg       <= ST_LINE;
                    end
                end
                ST_LINE: begin
                    state_reg <= line_wrap ? ST_PDIV : ST_FIN;
                end
                ST_PDIV: begin
                    if (div_rsp.done) begin
                        pmoved_reg      <= 1'b1;
                        page_number_reg <= page_number_reg + {1'b0, div_rsp.quotient};
                        head_line_reg   <= {7'b0, div_rsp.remainder};
                        state_reg       <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_column_reg     <= head_column_reg;
                        m_line_reg       <= head_line_reg;
                        m_page_reg       <= page_number_reg;
                        m_line_moved_reg <= lmoved_reg;
                        m_page_moved_reg <= pmoved_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_column     = m_column_reg;
    assign m_line       = m_line_reg;
    assign m_page       = m_page_reg;
    assign m_line_moved = m_line_moved_reg;
    assign m_page_moved = m_page_moved_reg;

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_CDIV || state_reg == ST_PDIV))
        else $error("divider finished outside a wait state");

    // A finished horizontal move leaves the column inside the line.
    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && !mode_reg |-> head_column_reg < cpl_eff)
        else $error("column not wrapped into the line");

    // A horizontal page wrap leaves the line inside the page.
    a_line_in_page: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && !mode_reg && pmoved_reg |-> head_line_reg < {7'b0, lpp_eff})
        else $error("line not wrapped into the page");

    // An accepted item always starts at the column step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_COL)
        else $error("accepted item did not start the sequence");

endmodule

// File: sim/tb_print_head_position_tracker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Print head position tracker testbench
// Moves the head by directed and random offsets under several line and page
// lengths, with random gaps on both channels and one long receiver stall.
// Every result item is checked field by field against a hand-typed position
// or a behavioral tracker that runs alongside the block.
// ---------------------------------------------------------------------------
module tb_print_head_position_tracker_top;

    // Move kinds carried by s_mode.
    localparam logic MOVE_COLUMNS = 1'b0;
    localparam logic MOVE_LINES   = 1'b1;

    localparam logic signed [pht_pkg::OFF_W-1:0] OFF_MIN =
        {1'b1, {(pht_pkg::OFF_W-1){1'b0}}};
    localparam logic signed [pht_pkg::OFF_W-1:0] OFF_MAX =
        {1'b0, {(pht_pkg::OFF_W-1){1'b1}}};

    localparam int RESET_CYCLES  = 7;
    // Long enough to cover the slowest move in flight.
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any handshake before the run is declared hung. It has to
    // cover the long receiver stall plus the slowest move and the settle time.
    localparam int STALL_LIMIT   = 4000;
    // A length of this value in the phase table is drawn at random.
    localparam int RANDOM_LEN    = -1;
    localparam int DIRECTED_N    = 24;
    localparam int PHASE_N       = 12;

    typedef struct packed {
        logic [pht_pkg::COL_W-1:0]  column;
        logic [pht_pkg::LINE_W-1:0] line;
        logic [pht_pkg::PAGE_W-1:0] page;
        logic                       line_moved;
        logic                       page_moved;
    } head_pos_t;

    // One directed move. When typed is set, pos holds the position read off
    // by hand; otherwise the expected position comes from the tracker below.
    typedef struct packed {
        logic                             mode;
        logic signed [pht_pkg::OFF_W-1:0] offset;
        logic                             typed;
        head_pos_t                        pos;
    } move_row_t;

    typedef struct packed {
        int   chars;
        int   lines;
        int   moves;
        logic squeeze;
    } phase_t;

    // The directed moves start from reset: 80 columns per line, 66 lines per page.
    localparam move_row_t DIRECTED_MOVES [DIRECTED_N] = '{
        // No move at all, then the last column of the first line.
        '{MOVE_COLUMNS, 13'sd0,   1'b1, '{8'd0,  15'd0,     16'd0,   1'b0, 1'b0}},
        '{MOVE_COLUMNS, 13'sd79,  1'b1, '{8'd79, 15'd0,     16'd0,   1'b0, 1'b0}},
        // One step past the line end wraps forward and flags the line.
        '{MOVE_COLUMNS, 13'sd1,   1'b1, '{8'd0,  15'd1,     16'd0,   1'b1, 1'b0}},
        // One step back wraps to the end of the previous line with no flag.
        '{MOVE_COLUMNS, -13'sd1,  1'b1, '{8'd79, 15'd0,     16'd0,   1'b0, 1'b0}},
        '{MOVE_COLUMNS, OFF_MAX,  1'b1, '{8'd14, 15'd52,    16'd0,   1'b1, 1'b0}},
        // Landing exactly on the page length does not turn the page.
        '{MOVE_LINES,   13'sd14,  1'b1, '{8'd14, 15'd66,    16'd0,   1'b1, 1'b0}},
        // Past the page length the page steps by one and the line stays put.
        '{MOVE_LINES,   13'sd1,   1'b1, '{8'd14, 15'd67,    16'd1,   1'b1, 1'b1}},
        // A zero vertical move still turns the page while the line is too far.
        '{MOVE_LINES,   13'sd0,   1'b1, '{8'd14, 15'd67,    16'd2,   1'b0, 1'b1}},
        '{MOVE_LINES,   OFF_MIN,  1'b1, '{8'd14, 15'd0,     16'd2,   1'b1, 1'b0}},
        // Moving up at line zero reports a line move although nothing changes.
        '{MOVE_LINES,   -13'sd1,  1'b1, '{8'd14, 15'd0,     16'd2,   1'b1, 1'b0}},
        '{MOVE_COLUMNS, OFF_MIN,  1'b1, '{8'd78, 15'd0,     16'd2,   1'b0, 1'b0}},
        // Climb to the line ceiling in big vertical steps.
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b0, '0},
        '{MOVE_LINES,   OFF_MAX,  1'b1, '{8'd78, 15'd32767, 16'd11,  1'b1, 1'b1}},
        // A forward wrap at the ceiling saturates, then wraps into pages.
        '{MOVE_COLUMNS, OFF_MAX,  1'b1, '{8'd13, 15'd31,    16'd507, 1'b1, 1'b1}},
        '{MOVE_COLUMNS, -13'sd14, 1'b0, '0},
        '{MOVE_LINES,   -13'sd31, 1'b0, '0},
        // Backward wrap at line zero keeps the line at zero.
        '{MOVE_COLUMNS, -13'sd80, 1'b0, '0}
    };

    // Length settings for the random part. Zero lengths act as one; a reduced
    // line length following a long one leaves the column beyond the line end.
    localparam phase_t PHASES [PHASE_N] = '{
        '{255,        255,        140, 1'b0},
        '{1,          1,          140, 1'b0},
        '{0,          0,          120, 1'b0},
        '{12,         5,          140, 1'b0},
        '{255,        1,          140, 1'b0},
        '{1,          255,        140, 1'b0},
        '{RANDOM_LEN, RANDOM_LEN, 140, 1'b0},
        '{80,         66,         140, 1'b0},
        '{7,          200,        140, 1'b0},
        '{RANDOM_LEN, RANDOM_LEN, 140, 1'b0},
        '{255,        255,        140, 1'b1},
        '{3,          2,          140, 1'b0}
    };

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_mode;
    logic signed [pht_pkg::OFF_W-1:0]    s_offset;
    logic                                m_valid;
    logic                                m_ready;
    logic [pht_pkg::COL_W-1:0]           m_column;
    logic [pht_pkg::LINE_W-1:0]          m_line;
    logic [pht_pkg::PAGE_W-1:0]          m_page;
    logic                                m_line_moved;
    logic                                m_page_moved;
    logic                                cfg_wen;
    logic [pht_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [pht_pkg::CFG_W-1:0]           cfg_wdata;

    // Behavioral copy of the tracker: lengths as written and head position.
    logic [pht_pkg::CFG_W-1:0]  chars_per_line;
    logic [pht_pkg::CFG_W-1:0]  lines_per_page;
    logic [pht_pkg::COL_W-1:0]  head_col;
    logic [pht_pkg::LINE_W-1:0] head_ln;
    logic [pht_pkg::PAGE_W-1:0] head_pg;

    // Positions predicted for accepted moves, oldest first.
    head_pos_t pending_positions[$];

    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_request;
    int   hold_left;

    print_head_position_tracker_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_offset     (s_offset),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column     (m_column),
        .m_line       (m_line),
        .m_page       (m_page),
        .m_line_moved (m_line_moved),
        .m_page_moved (m_page_moved),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int clamp_line(input int value);
        if (value < 0) return 0;
        if (value > int'(pht_pkg::LINE_MAX)) return int'(pht_pkg::LINE_MAX);
        return value;
    endfunction

    // Applies one move to the tracked head and returns the new position.
    function automatic head_pos_t move_head(input logic mode,
                                            input logic signed [pht_pkg::OFF_W-1:0] off);
        head_pos_t pos;
        int        step;
        int        col;
        int        ln;
        int        cpl;
        int        lpp;
        int        back;
        step = off;
        cpl  = (chars_per_line == '0) ? 1 : int'(chars_per_line);
        lpp  = (lines_per_page == '0) ? 1 : int'(lines_per_page);
        col  = int'(head_col);
        ln   = int'(head_ln);
        pos.line_moved = 1'b0;
        pos.page_moved = 1'b0;
        if (mode == MOVE_COLUMNS) begin
            col = col + step;
            if (col >= cpl) begin
                pos.line_moved = 1'b1;
                ln  = ln + col / cpl;
                col = col % cpl;
            end else if (col < 0) begin
                // Go back as many whole lines as it takes to get the column
                // non-negative again.
                back = (cpl - 1 - col) / cpl;
                ln   = ln - back;
                col  = col + back * cpl;
            end
            ln = clamp_line(ln);
            if (ln >= lpp) begin
                pos.page_moved = 1'b1;
                head_pg = head_pg + pht_pkg::PAGE_W'(ln / lpp);
                ln      = ln % lpp;
            end
            head_col = pht_pkg::COL_W'(col);
        end else begin
            pos.line_moved = (step != 0);
            ln = clamp_line(ln + step);
            // A vertical move turns at most one page and never wraps the line.
            if (ln > lpp) begin
                pos.page_moved = 1'b1;
                head_pg = head_pg + pht_pkg::PAGE_W'(1);
            end
        end
        head_ln    = pht_pkg::LINE_W'(ln);
        pos.column = head_col;
        pos.line   = head_ln;
        pos.page   = head_pg;
        return pos;
    endfunction

    // Writes one length register. Called at a falling edge, returns at one, and
    // drops the enable again before returning so back-to-back writes stay clean.
    task automatic write_length(input logic [pht_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[pht_pkg::CFG_W-1:0];
        if (idx == pht_pkg::CFG_CHARS_PER_LINE) begin
            chars_per_line = value[pht_pkg::CFG_W-1:0];
        end else begin
            lines_per_page = value[pht_pkg::CFG_W-1:0];
        end
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    // Offers one move after a random gap and waits until the block takes it.
    // Called at a falling edge and returns at the falling edge after the
    // handshake, with s_valid still high so the next move can follow at once.
    task automatic offer_move(input logic mode,
                              input logic signed [pht_pkg::OFF_W-1:0] off,
                              input logic typed, input head_pos_t typed_pos);
        head_pos_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_offset <= off;
        do @(posedge aclk); while (!s_ready);
        // The tracker always advances, even when the expected position of a
        // directed row is typed in by hand.
        predicted = move_head(mode, off);
        pending_positions.push_back(typed ? typed_pos : predicted);
        @(negedge aclk);
    endtask

    // Lets every outstanding result drain and the sequencer go idle, so that
    // the lengths can be rewritten safely.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_positions.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // Receiver: random back-pressure, or a long hold when one is requested so
    // that the output register fills and the block stops taking moves.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each result item is matched against the oldest prediction.
    always @(posedge aclk) begin
        head_pos_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: result with nothing expected: column %0d line %0d page %0d",
                         $time, m_column, m_line, m_page);
                errors++;
            end else begin
                want = pending_positions.pop_front();
                check_field("column", want.column, m_column);
                check_field("line", want.line, m_line);
                check_field("page", want.page, m_page);
                check_field("line_moved", want.line_moved, m_line_moved);
                check_field("page_moved", want.page_moved, m_page_moved);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb_print_head_position_tracker_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        int                               chars;
        int                               lines;
        int                               span;
        logic                             mode;
        logic signed [pht_pkg::OFF_W-1:0] off;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MOVE_COLUMNS;
        s_offset      = '0;
        m_ready       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = pht_pkg::CFG_CHARS_PER_LINE;
        cfg_wdata     = '0;
        errors        = 0;
        hold_request  = 1'b0;
        hold_left     = 0;
        // First stretch: the sender idles rarely, the receiver often.
        send_idle_pct = 20;
        recv_idle_pct = 80;

        chars_per_line = pht_pkg::CHARS_PER_LINE_RST;
        lines_per_page = pht_pkg::LINES_PER_PAGE_RST;
        head_col       = '0;
        head_ln        = '0;
        head_pg        = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed moves at the reset lengths.
        for (int r = 0; r < DIRECTED_N; r++) begin
            offer_move(DIRECTED_MOVES[r].mode, DIRECTED_MOVES[r].offset,
                       DIRECTED_MOVES[r].typed, DIRECTED_MOVES[r].pos);
        end
        settle();

        // Random moves, one length setting per phase. The idle pattern goes
        // from a slow receiver to a slow sender and finally to full speed.
        for (int p = 0; p < PHASE_N; p++) begin
            case (p / 4)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            chars = (PHASES[p].chars == RANDOM_LEN) ? int'($urandom_range(255))
                                                    : PHASES[p].chars;
            lines = (PHASES[p].lines == RANDOM_LEN) ? int'($urandom_range(255))
                                                    : PHASES[p].lines;
            write_length(pht_pkg::CFG_CHARS_PER_LINE, chars);
            write_length(pht_pkg::CFG_LINES_PER_PAGE, lines);

            for (int n = 0; n < PHASES[p].moves; n++) begin
                // A few moves into a squeeze phase, stall the receiver for a
                // long stretch while moves keep coming.
                if (PHASES[p].squeeze && n == 10) hold_request = 1'b1;
                mode = 1'($urandom_range(1));
                // Offsets around one line or page length reach both sides of every wrap; the
                // rest take the range ends, zero, minus one, any offset or one within 300 of zero.
                span = ((mode == MOVE_COLUMNS) ? int'(chars_per_line)
                                               : int'(lines_per_page)) + 1;
                case ($urandom_range(9)) inside
                    [0:1]: off = pht_pkg::OFF_W'($urandom);
                    2: begin
                        case ($urandom_range(3))
                            0: off = OFF_MIN;
                            1: off = OFF_MAX;
                            2: off = '0;
                            default: off = -13'sd1;
                        endcase
                    end
                    [3:5]: off = pht_pkg::OFF_W'(int'($urandom_range(2 * span)) - span);
                    default: off = pht_pkg::OFF_W'(int'($urandom_range(600)) - 300);
                endcase
                offer_move(mode, off, 1'b0, '0);
            end
            settle();
        end

        if (errors == 0) begin
            $display("tb_print_head_position_tracker_top OK");
        end else begin
            $display("tb_print_head_position_tracker_top NOT OK");
        end
        $finish;
    end

endmodule
